// ----- rtl/rfp_pkg.sv -----
package rfp_pkg;

   // Default buffer depth in bytes.
   localparam int MAX_LEN_DEFAULT = 64;

   // Field widths fixed by the interface.
   localparam int SYMBOL_W = 8;
   localparam int RAIL_W   = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = RAIL_W;

   // Zig-zag step and next-position widths (twice the rail count, plus one carry bit).
   localparam int STEP_W = RAIL_W + 1;
   localparam int NEXT_W = STEP_W + 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RAIL_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [RAIL_W-1:0] RAIL_COUNT_RESET = 7'd3;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                final_byte;
   } req_data_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] out_symbol;
      logic                out_last;
      logic                overflow;
   } rsp_data_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic walk_init;
      logic walk_step;
      logic idx_clear;
      logic emit_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic idx_last;
   } status_type;

endpackage

// ----- rtl/rfp_ctrl.sv -----
module rfp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                final_byte,
   input  rfp_pkg::status_type status,
   output rfp_pkg::cmd_type    cmd,
   output logic                busy
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (final_byte) begin
                  cmd.walk_init = 1'b1;
                  state_in      = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // The last permuted byte lands in the result buffer this cycle.
            cmd.idx_clear = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // A byte is taken only when the controller is idle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == ST_IDLE))
      else $error("load outside idle");

   // The end of every walk is followed by the flush state and then by emission.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_step && status.idx_last) |=> cmd.idx_clear ##1 cmd.emit_step)
      else $error("walk not followed by flush and emission");

   // The controller is busy once the final byte has been taken.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load && final_byte) |=> busy)
      else $error("not busy after final byte");
`endif

endmodule

// ----- rtl/rfp_datapath.sv -----
module rfp_datapath #(
   parameter int MAX_LEN = rfp_pkg::MAX_LEN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rfp_pkg::cmd_type                   cmd,
   output rfp_pkg::status_type                status,
   input  rfp_pkg::req_data_type              req_data,
   input  logic                               csr_write_en,
   input  logic [rfp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rfp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                               rsp_valid,
   output rfp_pkg::rsp_data_type              rsp_data
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int RW = rfp_pkg::RAIL_W;
   localparam int SW = rfp_pkg::STEP_W;
   localparam int NW = rfp_pkg::NEXT_W;

   // Message buffer and result buffer.
   logic [rfp_pkg::SYMBOL_W-1:0] msg_mem [MAX_LEN];
   logic [rfp_pkg::SYMBOL_W-1:0] res_mem [MAX_LEN];

   logic [RW-1:0]  rail_count_ff, rail_count_in;
   logic           decrypt_ff, decrypt_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           dropped_ff, dropped_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  rail_ff, rail_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic           phase_ff, phase_in;
   logic           wr_pend_ff, wr_pend_in;
   logic [AW-1:0]  wr_addr_ff, wr_addr_in;
   logic [rfp_pkg::SYMBOL_W-1:0] msg_rd_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rfp_pkg::rsp_data_type rsp_data_ff;

   logic           room;
   logic           single_rail;
   logic           edge_rail;
   logic [SW-1:0]  period;
   logic [SW-1:0]  twice_rail;
   logic [SW-1:0]  step;
   logic [NW-1:0]  next_pos;
   logic [AW-1:0]  msg_rd_addr;

   assign room            = (count_ff < CW'(MAX_LEN));
   assign status.idx_last = ((CW'(idx_ff) + CW'(1)) == count_ff);

   // Configuration registers.
   always_comb begin
      rail_count_in = rail_count_ff;
      decrypt_in    = decrypt_ff;
      if (csr_write_en) begin
         case (csr_index)
            rfp_pkg::CSR_RAIL_COUNT:   rail_count_in = csr_wdata;
            rfp_pkg::CSR_DECRYPT_MODE: decrypt_in    = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Byte count and drop flag; both clear once the last result goes out.
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end else if (cmd.emit_step && status.idx_last) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end
   end

   // Zig-zag walker. Rails 0 and R-1 step by the full period 2(R-1);
   // a middle rail r alternates 2(R-1)-2r and 2r. Zero or one rail steps by one.
   assign single_rail = (rail_count_ff < RW'(2));
   assign edge_rail   = (rail_ff == '0) || (RW'(rail_ff) == (rail_count_ff - RW'(1)));
   assign period      = {rail_count_ff - RW'(1), 1'b0};
   assign twice_rail  = SW'({rail_ff, 1'b0});

   always_comb begin
      if (single_rail) begin
         step = SW'(1);
      end else if (edge_rail) begin
         step = period;
      end else if (phase_ff) begin
         step = twice_rail;
      end else begin
         step = period - twice_rail;
      end
   end

   assign next_pos = NW'(pos_ff) + NW'(step);

   always_comb begin
      rail_in  = rail_ff;
      pos_in   = pos_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (cmd.walk_init) begin
         rail_in  = '0;
         pos_in   = '0;
         phase_in = 1'b0;
         idx_in   = '0;
      end else if (cmd.walk_step) begin
         idx_in = idx_ff + AW'(1);
         if (next_pos < NW'(count_ff)) begin
            pos_in   = next_pos[AW-1:0];
            phase_in = ~phase_ff;
         end else begin
            // Current rail is exhausted: start the next rail at its own index.
            rail_in  = rail_ff + AW'(1);
            pos_in   = rail_ff + AW'(1);
            phase_in = 1'b0;
         end
      end else if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.emit_step) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   // Encrypt gathers from the rail order; decrypt scatters into it.
   assign msg_rd_addr = decrypt_ff ? idx_ff : pos_ff;
   assign wr_pend_in  = cmd.walk_step;
   assign wr_addr_in  = decrypt_ff ? pos_ff : idx_ff;

   assign rsp_valid_in = cmd.emit_step;

   // Message buffer: one write port for loading, one registered read port for the walk.
   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         msg_mem[count_ff[AW-1:0]] <= req_data.symbol;
      end
      msg_rd_ff <= msg_mem[msg_rd_addr];
   end

   // Result buffer: written in the cycle after each walk step, read in position order.
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         res_mem[wr_addr_ff] <= msg_rd_ff;
      end
      if (cmd.emit_step) begin
         rsp_data_ff.out_symbol <= res_mem[idx_ff];
         rsp_data_ff.out_last   <= status.idx_last;
         rsp_data_ff.overflow   <= dropped_ff;
      end
   end

   // Walker and address registers.
   always_ff @(posedge clock) begin
      rail_ff    <= rail_in;
      pos_ff     <= pos_in;
      phase_ff   <= phase_in;
      idx_ff     <= idx_in;
      wr_addr_ff <= wr_addr_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rail_count_ff <= rfp_pkg::RAIL_COUNT_RESET;
         decrypt_ff    <= 1'b0;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rail_count_ff <= rail_count_in;
         decrypt_ff    <= decrypt_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // The stored byte count never exceeds the buffer depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LEN))
      else $error("byte count beyond buffer depth");

   // The walker only visits positions of the stored message.
   assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (CW'(pos_ff) < count_ff))
      else $error("walker outside message");

   // The final result clears the message state.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_step && status.idx_last) |=> (count_ff == '0) && !dropped_ff)
      else $error("message state not cleared after emission");

   // The result marked last ends the burst.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.out_last) |=> !rsp_valid_ff)
      else $error("result after last of message");
`endif

endmodule

// ----- rtl/rail_fence_permuter_core.sv -----
// Channel   Ports                                  Transfer when
// ------    -----                                  -------------
// request   start, busy, req_data                  start high and busy low
// result    rsp_valid, rsp_data                    rsp_valid high (one cycle, no stall)
// config    csr_write_en, csr_index, csr_wdata     csr_write_en high
//
// Bytes load at one per cycle while busy is low. The byte flagged final starts the
// permutation: the zig-zag walk reads each byte (one message buffer read per cycle),
// a flush state completes the last result write, and then the results stream out.
// Busy thus stays high from the final byte until the last result is sent.
// Reset is synchronous and active high; rails return to three, encrypt mode.
// Results cannot be stalled; each is shown for exactly one cycle.
module rail_fence_permuter_core #(
   parameter int MAX_LEN = rfp_pkg::MAX_LEN_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  rfp_pkg::req_data_type          req_data,
   output logic                           rsp_valid,
   output rfp_pkg::rsp_data_type          rsp_data,
   input  logic                           csr_write_en,
   input  logic [rfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   rfp_pkg::cmd_type    cmd;
   rfp_pkg::status_type status;

   // Sequencer.
   rfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .final_byte (req_data.final_byte),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   // Buffers, walker and result register.
   rfp_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

// ----- bench/tb_rail_fence_permuter_core.sv -----
module tb_rail_fence_permuter_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF_DEPTH = rfp_pkg::MAX_LEN_DEFAULT;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   rfp_pkg::req_data_type          req_data = '0;
   logic                           rsp_valid;
   rfp_pkg::rsp_data_type          rsp_data;
   logic                           csr_write_en = 1'b0;
   logic [rfp_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rfp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Bytes waiting for the driver, and permuted bytes waiting for the monitor.
   rfp_pkg::req_data_type pending_bytes_q[$];
   rfp_pkg::rsp_data_type expected_out_q[$];

   // Predictor copy of the block: register settings and the message being collected.
   logic [rfp_pkg::RAIL_W-1:0] rail_setting = rfp_pkg::RAIL_COUNT_RESET;
   logic                       decrypt_setting = 1'b0;
   logic [7:0]                 held_bytes[$];
   logic                       lost_bytes = 1'b0;

   int sender_idle_pct = 0;
   int error_count = 0;
   int message_count = 0;
   int byte_count = 0;
   int checked_count = 0;
   int overflow_msg_count = 0;
   logic send_now;
   rfp_pkg::rsp_data_type want;

   rail_fence_permuter_core dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #10 clock = ~clock;

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
               $time, what, got, exp_val);
      error_count++;
   endtask

   // Store one accepted byte; on the final byte, permute the message along the
   // zig-zag and queue one expected result per stored byte.
   task automatic permute_message(input rfp_pkg::req_data_type item);
      int                    rail_of [BUF_DEPTH];
      int                    slot_pos[BUF_DEPTH];
      logic [7:0]            permuted[BUF_DEPTH];
      int                    len;
      int                    rails;
      int                    rail;
      bit                    falling;
      int                    k;
      rfp_pkg::rsp_data_type res;
      if (held_bytes.size() < BUF_DEPTH) begin
         held_bytes.insert(held_bytes.size(), item.symbol);
      end else begin
         lost_bytes = 1'b1;
      end
      if (!item.final_byte) return;

      len = held_bytes.size();
      rails = (rail_setting == 0) ? 1 : int'(rail_setting);
      rail = 0;
      falling = 1'b0;
      for (int i = 0; i < len; i++) begin
         rail_of[i] = rail;
         if (rails > 1) begin
            if (rail == 0) falling = 1'b0;
            else if (rail == rails - 1) falling = 1'b1;
            rail = falling ? rail - 1 : rail + 1;
         end
      end
      // Slot k in rail order takes message position slot_pos[k].
      k = 0;
      for (int r = 0; r < rails; r++) begin
         for (int i = 0; i < len; i++) begin
            if (rail_of[i] == r) begin
               slot_pos[k] = i;
               k++;
            end
         end
      end
      for (int j = 0; j < len; j++) begin
         if (decrypt_setting) permuted[slot_pos[j]] = held_bytes[j];
         else permuted[j] = held_bytes[slot_pos[j]];
      end
      for (int j = 0; j < len; j++) begin
         res.out_symbol = permuted[j];
         res.out_last   = (j == len - 1);
         res.overflow   = lost_bytes;
         expected_out_q.insert(expected_out_q.size(), res);
      end
      message_count++;
      if (lost_bytes) overflow_msg_count++;
      held_bytes.delete();
      lost_bytes = 1'b0;
   endtask

   // Driver: a transfer happens at an edge where start is high and busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            permute_message(req_data);
            void'(pending_bytes_q.pop_front());
            byte_count++;
         end
         send_now = (pending_bytes_q.size() != 0) &&
                    ($urandom_range(99) >= sender_idle_pct);
         start <= send_now;
         if (send_now) req_data <= pending_bytes_q[0];
      end
   end

   // Monitor: each strobed result is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_out_q.size() == 0) begin
            report_mismatch("result with nothing expected", 32'(rsp_data), '0);
         end else begin
            want = expected_out_q.pop_front();
            checked_count++;
            if (rsp_data.out_symbol !== want.out_symbol)
               report_mismatch("out_symbol", 32'(rsp_data.out_symbol),
                               32'(want.out_symbol));
            if (rsp_data.out_last !== want.out_last)
               report_mismatch("out_last", 32'(rsp_data.out_last), 32'(want.out_last));
            if (rsp_data.overflow !== want.overflow)
               report_mismatch("overflow", 32'(rsp_data.overflow), 32'(want.overflow));
         end
      end
   end

   task automatic queue_byte(input logic [7:0] sym, input logic fin);
      rfp_pkg::req_data_type item;
      item.symbol     = sym;
      item.final_byte = fin;
      pending_bytes_q.insert(pending_bytes_q.size(), item);
   endtask

   task automatic queue_random_message(input int len);
      for (int i = 0; i < len; i++) queue_byte(8'($urandom), i == len - 1);
   endtask

   // Write one register; only called while the block is idle.
   task automatic write_csr(input logic [rfp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rfp_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == rfp_pkg::CSR_RAIL_COUNT) rail_setting = data;
      else decrypt_setting = data[0];
   endtask

   // Decrypt mode lives in bit zero; the upper bits carry random junk.
   task automatic set_mode(input int rails, input bit mode);
      write_csr(rfp_pkg::CSR_RAIL_COUNT, rfp_pkg::RAIL_W'(rails));
      write_csr(rfp_pkg::CSR_DECRYPT_MODE, {6'($urandom), mode});
   endtask

   // Hold off until every queued byte is sent and every result has come out.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_bytes_q.size() != 0 || expected_out_q.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int rails, input bit mode, input int idle_pct,
                            input int n_bytes, input int min_len, input int max_len);
      int queued;
      set_mode(rails, mode);
      sender_idle_pct = idle_pct;
      queued = 0;
      while (queued < n_bytes) begin
         int len;
         len = $urandom_range(max_len, min_len);
         queue_random_message(len);
         queued += len;
      end
      wait_drained();
   endtask

   // Stimulus sequence.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, one message at a time so the sender waits for every result.
      // Reset settings: three rails, encrypt; single-byte message first.
      queue_byte(8'hFF, 1'b1);
      wait_drained();
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h55, 1'b0);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h7F, 1'b1);
      wait_drained();
      // One rail passes the message through.
      write_csr(rfp_pkg::CSR_RAIL_COUNT, 7'd1);
      queue_random_message(4);
      wait_drained();
      // Zero rails behaves like one rail.
      write_csr(rfp_pkg::CSR_RAIL_COUNT, 7'd0);
      queue_random_message(3);
      wait_drained();
      // More rails than bytes, decrypting.
      set_mode(64, 1'b1);
      queue_random_message(5);
      wait_drained();
      set_mode(2, 1'b1);
      queue_random_message(5);
      wait_drained();

      // Random part: several settings and idle levels, short messages mostly.
      run_phase(127, 1'b0, 0, 10, 1, 12);
      run_phase(2, 1'b0, 50, 10, 1, 10);
      run_phase($urandom_range(9, 3), 1'b1, 16, 10, 1, 12);
      run_phase($urandom_range(127, 0), 1'($urandom_range(1)), 0, 10, 2, 30);
      run_phase($urandom_range(6, 2), 1'b0, 50, 10, 1, 8);
      // Overflow: the buffer fills and the last bytes, final one included, drop.
      run_phase(7, 1'b1, 16, 66, 66, 66);
      run_phase(3, 1'b0, 0, 10, 1, 6);

      repeat (2 * BUF_DEPTH + 8) @(posedge clock);
      if (expected_out_q.size() != 0)
         report_mismatch("results never produced", expected_out_q.size(), 0);
      $display("Covered %0d messages (%0d with dropped bytes), %0d bytes sent,",
               message_count, overflow_msg_count, byte_count);
      $display("%0d permuted bytes checked, over rail counts 0 to 127 in both modes.",
               checked_count);
      if (error_count == 0) begin
         $display("PASS rail_fence_permuter_core");
      end else begin
         $display("FAIL rail_fence_permuter_core");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("FAIL rail_fence_permuter_core");
      $finish;
   end

endmodule
